/* hdl/whot_pkg.sv */
// ----------------------------------------------------------------------------
// whot_pkg
// Shared types and constants for the write history overlap table.
// ----------------------------------------------------------------------------
package whot_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_SPARE  = 2'd3;

	localparam int TDATA_W = 512;
	localparam int IUSER_W = 4;
	localparam int OUSER_W = 3;

	typedef struct packed {
		logic [63:0] seq;
		logic [1:0]  kind;
		logic [63:0] addr;
		logic [63:0] size;
		logic [63:0] submit;
		logic [63:0] item;
		logic [63:0] order;
		logic [63:0] identity;
		logic [31:0] width;
		logic [31:0] height;
	} entry_t;

endpackage

/* hdl/whot_ram.sv */
// ----------------------------------------------------------------------------
// whot_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module whot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/write_history_overlap_table.sv */
// ----------------------------------------------------------------------------
// write_history_overlap_table
// Bounded history of write events with record, overlap query and clear.
// ----------------------------------------------------------------------------
// Record and query each walk the whole entry memory through one read port, one
// entry per cycle. A query then goes to its result; a record first passes a
// write-back state. Clear, an ignored record, an invalid query and the unused
// command go straight from accept to their result. One command at a time;
// s_tready is high only between commands and returns as the result is loaded
// into the output register; a result held by the receiver keeps it low.
module write_history_overlap_table #(
	parameter int TABLE_ENTRIES = whot_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// start_address, byte_count, submit_id, item_id, order_id, writer_identity,
	// surface_width, surface_height, sequence_limit
	input  logic [whot_pkg::TDATA_W-1:0] s_tdata,
	// command, writer_kind
	input  logic [whot_pkg::IUSER_W-1:0] s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// sequence_out, found_address, found_size, found_submit, found_item,
	// found_order, found_identity, found_width, found_height
	output logic [whot_pkg::TDATA_W-1:0] m_tdata,
	// found, found_kind
	output logic [whot_pkg::OUSER_W-1:0] m_tuser
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
	localparam int EW = $bits(whot_pkg::entry_t);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]               state_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [63:0]              cnt_q;
	logic                     m_tvalid_q;
	logic                     issue_q;
	logic                     proc_s1;
	logic                     rec_ok_q;
	logic                     qry_ok_q;

	logic [whot_pkg::TDATA_W-1:0] in_data_q;
	logic [1:0]                   in_kind_q;
	logic [63:0]                  qend_q;
	logic [AW-1:0]                idx_q;
	logic [AW-1:0]                pidx_s1;
	logic                         v_s1;
	logic                         match_q, free_q, old_q, best_q;
	logic [AW-1:0]                match_idx_q, free_idx_q, old_idx_q;
	logic [63:0]                  old_seq_q;
	whot_pkg::entry_t             best_e_q;
	logic [whot_pkg::TDATA_W-1:0] m_tdata_q;
	logic [whot_pkg::OUSER_W-1:0] m_tuser_q;

	logic             accept;
	logic [1:0]       in_cmd;
	logic [63:0]      in_addr, in_size;
	logic [64:0]      in_sum;
	logic             rd_en, wr_en;
	logic [AW-1:0]    slot;
	logic [EW-1:0]    rd_raw;
	whot_pkg::entry_t rd_e, wr_e;
	logic [64:0]      e_sum;
	logic [63:0]      e_end;
	logic             key_hit, older, better;
	logic             out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign in_cmd  = s_tuser[1:0];
	assign in_addr = s_tdata[63:0];
	assign in_size = s_tdata[127:64];
	assign in_sum  = {1'b0, in_addr} + {1'b0, in_size};

	assign rd_en = (state_q == ST_SCAN) && issue_q;
	assign wr_en = (state_q == ST_WRITE);
	assign slot  = match_q ? match_idx_q : (free_q ? free_idx_q : old_idx_q);

	assign wr_e.seq      = cnt_q;
	assign wr_e.kind     = in_kind_q;
	assign wr_e.addr     = in_data_q[63:0];
	assign wr_e.size     = in_data_q[127:64];
	assign wr_e.submit   = in_data_q[191:128];
	assign wr_e.item     = in_data_q[255:192];
	assign wr_e.order    = in_data_q[319:256];
	assign wr_e.identity = in_data_q[383:320];
	assign wr_e.width    = in_data_q[415:384];
	assign wr_e.height   = in_data_q[447:416];

	whot_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(slot),
		.wr_data(wr_e),
		.rd_en  (rd_en),
		.rd_addr(idx_q),
		.rd_data(rd_raw)
	);

	assign rd_e    = whot_pkg::entry_t'(rd_raw);
	assign e_sum   = {1'b0, rd_e.addr} + {1'b0, rd_e.size};
	assign e_end   = e_sum[64] ? '1 : e_sum[63:0];
	assign key_hit = (rd_e.kind == in_kind_q) && (rd_e.addr == in_data_q[63:0]);
	assign older   = !old_q || (rd_e.seq < old_seq_q);
	assign better  = (rd_e.seq < in_data_q[511:448]) && (in_data_q[63:0] < e_end) &&
			(rd_e.addr < qend_q) && (!best_q || (rd_e.seq > best_e_q.seq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			issue_q    <= 1'b0;
			proc_s1    <= 1'b0;
			rec_ok_q   <= 1'b0;
			qry_ok_q   <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			proc_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rec_ok_q <= (in_cmd == whot_pkg::CMD_RECORD) &&
								(in_addr != '0) && (in_size != '0);
						qry_ok_q <= (in_cmd == whot_pkg::CMD_QUERY) &&
								(in_addr != '0) && (in_size != '0);
						if ((in_cmd == whot_pkg::CMD_RECORD || in_cmd == whot_pkg::CMD_QUERY)
								&& in_addr != '0 && in_size != '0) begin
							state_q <= ST_SCAN;
							issue_q <= 1'b1;
							if (in_cmd == whot_pkg::CMD_RECORD) begin
								cnt_q <= cnt_q + 64'd1;
							end
						end else begin
							state_q <= ST_DONE;
							if (in_cmd == whot_pkg::CMD_CLEAR) begin
								valid_q <= '0;
								cnt_q   <= '0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (issue_q && idx_q == LAST) begin
						issue_q <= 1'b0;
					end
					if (proc_s1 && pidx_s1 == LAST) begin
						state_q <= rec_ok_q ? ST_WRITE : ST_DONE;
					end
				end
				ST_WRITE: begin
					valid_q[slot] <= 1'b1;
					state_q       <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pidx_s1 <= idx_q;
		v_s1    <= valid_q[idx_q];
		if (accept) begin
			in_data_q <= s_tdata;
			in_kind_q <= s_tuser[3:2];
			qend_q    <= in_sum[64] ? '1 : in_sum[63:0];
			idx_q     <= '0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
			old_q     <= 1'b0;
			best_q    <= 1'b0;
		end
		if (rd_en && idx_q != LAST) begin
			idx_q <= idx_q + AW'(1);
		end
		if (state_q == ST_SCAN && proc_s1) begin
			if (v_s1) begin
				if (!match_q && key_hit) begin
					match_q     <= 1'b1;
					match_idx_q <= pidx_s1;
				end
				if (older) begin
					old_q     <= 1'b1;
					old_idx_q <= pidx_s1;
					old_seq_q <= rd_e.seq;
				end
				if (better) begin
					best_q   <= 1'b1;
					best_e_q <= rd_e;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= pidx_s1;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			if (qry_ok_q && best_q) begin
				m_tdata_q <= {best_e_q.height, best_e_q.width, best_e_q.identity,
						best_e_q.order, best_e_q.item, best_e_q.submit,
						best_e_q.size, best_e_q.addr, best_e_q.seq};
				m_tuser_q <= {best_e_q.kind, 1'b1};
			end else begin
				m_tdata_q <= {{(whot_pkg::TDATA_W - 64){1'b0}},
						(rec_ok_q ? cnt_q : 64'd0)};
				m_tuser_q <= '0;
			end
		end
	end

endmodule
